>>> src/iphft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP fragment hole tracker package
// Shared types, constants and state encoding for the hole tracker.
// ----------------------------------------------------------------------------
package iphft_pkg;

	localparam int unsigned MAX_HOLES_DEF = 16;

	typedef struct packed {
		logic        starts_datagram;
		logic [12:0] offset_units;
		logic [15:0] payload_bytes;
		logic        more_fragments;
	} frag_t;

	typedef struct packed {
		logic        complete;
		logic [15:0] dgram_length;
		logic [4:0]  holes_left;
		logic        hole_overflow;
	} res_t;

	typedef struct packed {
		logic [15:0] hole_start;
		logic [15:0] hole_end;
	} hole_t;

	localparam hole_t HOLE_FULL = '{hole_start: 16'h0000, hole_end: 16'hFFFF};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} state_t;

endpackage

>>> src/iphft_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP fragment hole tracker channels
// Valid/ready channels for fragment beats and result beats.
// ----------------------------------------------------------------------------
interface iphft_frag_if;
	import iphft_pkg::*;

	logic  valid;
	logic  ready;
	frag_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface iphft_res_if;
	import iphft_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/iphft_hole_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hole descriptor memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iphft_hole_mem #(
	parameter int unsigned MAX_HOLES = iphft_pkg::MAX_HOLES_DEF
) (
	input  logic                         clk,
	input  logic [$clog2(MAX_HOLES)-1:0] rd_addr,
	output iphft_pkg::hole_t             rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_HOLES)-1:0] wr_addr,
	input  iphft_pkg::hole_t             wr_data
);
	import iphft_pkg::*;

	hole_t mem [MAX_HOLES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> src/iphft_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hole tracker control
// Walks the hole table once per fragment unless already complete, trims
// entries in place and allocates the split-off right hole after the walk.
// ----------------------------------------------------------------------------
module iphft_ctrl #(
	parameter int unsigned MAX_HOLES = iphft_pkg::MAX_HOLES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  iphft_pkg::frag_t             in_data,
	output logic                         fin_valid,
	input  logic                         fin_ready,
	output iphft_pkg::res_t              fin_data,
	output logic [$clog2(MAX_HOLES)-1:0] rd_addr,
	input  iphft_pkg::hole_t             rd_data,
	output logic                         wr_en,
	output logic [$clog2(MAX_HOLES)-1:0] wr_addr,
	output iphft_pkg::hole_t             wr_data
);
	import iphft_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_HOLES);
	localparam int unsigned CNT_W = $clog2(MAX_HOLES + 1);
	localparam logic [IDX_W:0] IDX_END = (IDX_W + 1)'(MAX_HOLES);

	state_t               state_q, state_d;
	logic [IDX_W:0]       idx_q;
	logic                 start_q;
	logic                 mf_q;
	logic [15:0]          ff_q;
	logic [17:0]          flp1_q;
	logic [MAX_HOLES-1:0] vld_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [15:0]          len_q;
	logic                 done_q;
	logic                 split_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [15:0]          split_start_q;
	logic [15:0]          split_end_q;
	logic                 proc_s1;
	logic [IDX_W-1:0]     proc_idx_s1;

	logic             accept;
	logic             active;
	logic [15:0]      off_bytes;
	logic [16:0]      last_sum;
	hole_t            cur;
	hole_t            wb;
	logic             cur_v;
	logic             ovl;
	logic             keep_l;
	logic             need_r;
	logic             drop;
	logic             split_now;
	logic             entry_free;
	logic             alloc_ok;
	logic [CNT_W-1:0] cnt_new;

	assign accept    = in_valid && in_ready;
	assign active    = in_data.starts_datagram || !done_q;
	assign off_bytes = {in_data.offset_units, 3'b000};
	assign last_sum  = 17'(off_bytes) + 17'(in_data.payload_bytes);

	always_comb begin
		cur        = (start_q && proc_idx_s1 == '0) ? HOLE_FULL : rd_data;
		cur_v      = proc_s1 && vld_q[proc_idx_s1];
		ovl        = cur_v && !(ff_q > cur.hole_end) && !(flp1_q <= 18'(cur.hole_start));
		keep_l     = ff_q > cur.hole_start;
		need_r     = mf_q && (flp1_q <= 18'(cur.hole_end));
		drop       = ovl && !keep_l && !need_r;
		split_now  = ovl && keep_l && need_r;
		entry_free = proc_s1 && (!cur_v || drop);
		wb         = cur;
		if (ovl && keep_l) begin
			wb.hole_end = ff_q - 16'd1;
		end else if (ovl && need_r) begin
			wb.hole_start = flp1_q[15:0];
		end
		alloc_ok = split_q && free_found_q;
		cnt_new  = cnt_q + CNT_W'(alloc_ok);
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		fin_valid = 1'b0;
		rd_addr   = idx_q[IDX_W-1:0];
		wr_en     = cur_v && !drop;
		wr_addr   = proc_idx_s1;
		wr_data   = wb;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = active ? ST_WALK : ST_FIN;
				end
			end
			ST_WALK: begin
				if (idx_q == IDX_END) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				fin_valid = 1'b1;
				wr_en     = fin_ready && alloc_ok;
				wr_addr   = free_idx_q;
				wr_data   = '{hole_start: split_start_q, hole_end: split_end_q};
				if (fin_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign fin_data = '{
		complete:      cnt_new == '0,
		dgram_length:  len_q,
		holes_left:    5'(cnt_new),
		hole_overflow: split_q && !free_found_q
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			proc_s1      <= 1'b0;
			vld_q        <= '0;
			cnt_q        <= '0;
			len_q        <= '0;
			done_q       <= 1'b0;
			split_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			proc_s1 <= (state_q == ST_WALK) && (idx_q != IDX_END);
			if (accept) begin
				idx_q        <= '0;
				split_q      <= 1'b0;
				free_found_q <= 1'b0;
				if (in_data.starts_datagram) begin
					vld_q <= MAX_HOLES'(1);
					cnt_q <= CNT_W'(1);
				end
				if (active && !in_data.more_fragments) begin
					len_q <= last_sum[16] ? 16'hFFFF : last_sum[15:0];
				end else if (in_data.starts_datagram) begin
					len_q <= '0;
				end
			end else if (state_q == ST_WALK && idx_q != IDX_END) begin
				idx_q <= idx_q + 1'b1;
			end
			if (drop) begin
				vld_q[proc_idx_s1] <= 1'b0;
				cnt_q              <= cnt_q - 1'b1;
			end
			if (split_now) begin
				split_q <= 1'b1;
			end
			if (entry_free && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (state_q == ST_FIN && fin_ready) begin
				if (alloc_ok) begin
					vld_q[free_idx_q] <= 1'b1;
				end
				cnt_q  <= cnt_new;
				done_q <= cnt_new == '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		proc_idx_s1 <= idx_q[IDX_W-1:0];
		if (accept) begin
			start_q <= in_data.starts_datagram;
			mf_q    <= in_data.more_fragments;
			ff_q    <= off_bytes;
			flp1_q  <= 18'(off_bytes) + 18'(in_data.payload_bytes);
		end
		if (split_now) begin
			split_start_q <= flp1_q[15:0];
			split_end_q   <= cur.hole_end;
		end
		if (entry_free && !free_found_q) begin
			free_idx_q <= proc_idx_s1;
		end
	end

endmodule

>>> src/ip_fragment_hole_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP fragment hole tracker
// Follows the reassembly of one IPv4 datagram with a table of hole ranges.
// ----------------------------------------------------------------------------
// Usage: each fragment beat on frag carries the start flag, the offset in
// 8-byte units, the payload length and the MF flag. Exactly one result beat
// on res follows each fragment, giving completion, total length, the number
// of remaining holes and a table overflow flag.
// The single read port of the hole memory paces a fragment: every entry
// is read once per walked fragment, then the final state places a
// split-off hole and loads the result register, which drives res.
// A fragment that arrives after completion and does not start a datagram
// skips the walk and goes straight to the final state.
// A new fragment is taken only once the result of the previous one has
// moved into the result register.
// Reset clears all hole valid bits, the total length and the done flag; the
// hole memory itself is not cleared. When res is stalled the result stays
// in its register; the next fragment is still accepted and walked, and its
// result waits until the register is freed.
// ----------------------------------------------------------------------------
module ip_fragment_hole_tracker #(
	parameter int unsigned MAX_HOLES = iphft_pkg::MAX_HOLES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	iphft_frag_if.sink   frag,
	iphft_res_if.source  res
);
	import iphft_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_HOLES);

	logic             fin_valid;
	logic             fin_ready;
	res_t             fin_data;
	logic [IDX_W-1:0] rd_addr;
	hole_t            rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	hole_t            wr_data;
	logic             out_vld_q;
	res_t             res_q;

	iphft_ctrl #(
		.MAX_HOLES(MAX_HOLES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frag.valid),
		.in_ready (frag.ready),
		.in_data  (frag.data),
		.fin_valid(fin_valid),
		.fin_ready(fin_ready),
		.fin_data (fin_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	iphft_hole_mem #(
		.MAX_HOLES(MAX_HOLES)
	) u_mem (
		.clk    (clk),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign fin_ready = !out_vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fin_ready) begin
			out_vld_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_ready && fin_valid) begin
			res_q <= fin_data;
		end
	end

	assign res.valid = out_vld_q;
	assign res.data  = res_q;

endmodule

>>> src/iphft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hole tracker port checker
// Checks result beats against the fragment channel and each other.
// ----------------------------------------------------------------------------
module iphft_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input iphft_pkg::res_t  out_data
);
	import iphft_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Result beat dropped or changed while stalled.");

	a_complete_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.complete |-> out_data.holes_left == 5'd0)
		else $error("Complete result still reports holes.");

	a_complete_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.complete |-> !out_data.hole_overflow)
		else $error("Complete result reports a lost hole.");

	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("Result beat appeared one cycle after a fragment beat.");

endmodule

bind ip_fragment_hole_tracker iphft_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (frag.valid),
	.in_ready (frag.ready),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.out_data (res.data)
);
